/* rtl/core/sld_pkg.sv */
`timescale 1ns / 1ps

package sld_pkg;

  // counter width, counters saturate at all ones
  localparam int unsigned COUNT_BITS = 32;

  // packet store geometry
  localparam int unsigned STORE_DEPTH = 45;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

  // framing constants
  localparam logic [7:0] SYNC_RESET    = 8'hAA;
  localparam logic [7:0] PRIMARY_RESET = 8'h87;
  localparam logic [7:0] SIGNAL_RESET  = 8'h98;
  localparam logic [7:0] PRIMARY_LEN   = 8'd45;
  localparam logic [7:0] SIGNAL_LEN    = 8'd2;
  localparam logic [5:0] CRC_SPAN      = 6'd43;
  localparam logic [5:0] CRC_LO_POS    = 6'd43;
  localparam logic [5:0] SIG_DATA_POS  = 6'd1;
  localparam logic [15:0] CRC_POLY     = 16'h1021;

  // first payload byte of the field readout
  localparam logic [STORE_AW-1:0] FIELD_BASE = STORE_AW'(1);
  localparam logic [3:0] LAST_FIELD = 4'd15;
  localparam logic [3:0] FIRST_HALF_FIELD = 4'd6;
  localparam logic [3:0] FIRST_BYTE_FIELD = 4'd14;

  // result kinds
  localparam logic [1:0] KIND_FIELD  = 2'd0;
  localparam logic [1:0] KIND_SIGNAL = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SYNC    = 2'd0;
  localparam logic [1:0] CFG_PRIMARY = 2'd1;
  localparam logic [1:0] CFG_SIGNAL  = 2'd2;

  typedef enum logic [2:0] {
    ST_SYNC1,
    ST_SYNC2,
    ST_LEN,
    ST_DATA,
    ST_VERDICT,
    ST_SHIFT,
    ST_EMIT
  } sld_state_e;

  typedef enum logic [1:0] {
    V_DROP,
    V_ERROR,
    V_SIGNAL,
    V_PRIMARY
  } sld_verdict_e;

  typedef struct packed {
    logic start_pkt;
    logic data_take;
    logic finish;
    logic rd_issue;
    logic shift;
    logic load_field;
    logic load_single;
  } sld_cmd_t;

  typedef struct packed {
    logic         sync_match;
    logic         len_ok;
    logic         last_byte;
    sld_verdict_e verdict;
    logic         field_done;
    logic         last_field;
    logic         out_free;
  } sld_stat_t;

  // crc-16, poly 0x1021, msb first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // byte count minus one for each payload field
  function automatic logic [1:0] field_nb_last(input logic [3:0] field);
    logic [1:0] n;
    if (field < FIRST_HALF_FIELD) begin
      n = 2'd3;
    end else if (field < FIRST_BYTE_FIELD) begin
      n = 2'd1;
    end else begin
      n = 2'd0;
    end
    return n;
  endfunction

endpackage

/* rtl/core/sld_byte_if.sv */
`timescale 1ns / 1ps

interface sld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

/* rtl/core/sld_cfg_if.sv */
`timescale 1ns / 1ps

interface sld_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/sld_res_if.sv */
`timescale 1ns / 1ps

interface sld_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         packet_kind;
  logic [3:0]         field_index;
  logic signed [31:0] field_value;
  logic               last_of_packet;
  logic [31:0]        good_count;
  logic [31:0]        broken_count;
  logic [31:0]        checked_count;

  modport source (output valid, output packet_kind, output field_index, output field_value,
                  output last_of_packet, output good_count, output broken_count,
                  output checked_count, input ready);
  modport sink (input valid, input packet_kind, input field_index, input field_value,
                input last_of_packet, input good_count, input broken_count,
                input checked_count, output ready);
endinterface

/* rtl/core/sync_length_crc16_packet_deframer.sv */
`timescale 1ns / 1ps

// channel  | dir | payload                                  | word accepted when
// ---------+-----+------------------------------------------+--------------------
// in_i     | in  | in_byte                                  | in_i.valid & ready
// cfg_i    | in  | index (0 sync, 1 primary id, 2 sig. id)  | cfg_i.valid & ready
// res_o    | out | kind, index, value, last, three counters | res_o.valid & ready
//
// one input word per cycle while hunting sync and collecting packet bytes
// after the last packet byte: a verdict state, which also loads a signal or error
// word, then for a primary packet the field readout (store reads and field loads)
// input is held off during that readout; output stalls stretch it word for word
// async active-low reset returns to the sync hunt and clears the counters
// the packet store is not cleared; only bytes of the current packet are read

module sync_length_crc16_packet_deframer import sld_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  sld_byte_if.sink  in_i,
  sld_cfg_if.sink   cfg_i,
  sld_res_if.source res_o
);

  sld_cmd_t  cmd;
  sld_stat_t stat;
  logic      in_ready;

  assign in_i.ready = in_ready;

  // framing state machine: hunt, length, collect, verdict, field readout
  sld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // store, running crc, counters, field assembly and result register
  sld_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_byte_i (in_i.in_byte),
    .cfg_i     (cfg_i),
    .res_o     (res_o),
    .cmd_i     (cmd),
    .stat_o    (stat)
  );

`ifndef ASSERT_OFF
  // a packet verdict is only taken on an accepted byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (in_i.valid && in_i.ready))
    else $error("verdict taken without an accepted byte");

  // a result word is only loaded when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_field || cmd.load_single) |-> stat.out_free)
    else $error("result loaded over a waiting word");

  // no input while a primary packet is still being read out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.last_of_packet) |-> !in_i.ready)
    else $error("input taken during field readout");

  // signal and error words close their packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.packet_kind != KIND_FIELD) |-> res_o.last_of_packet)
    else $error("single word not marked last");
`endif

endmodule

/* rtl/core/sld_store_ram.sv */
`timescale 1ns / 1ps

module sld_store_ram #(
  parameter int unsigned Depth = 45,
  parameter int unsigned Width = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/sld_ctrl.sv */
`timescale 1ns / 1ps

module sld_ctrl import sld_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sld_stat_t stat_i,
  output sld_cmd_t  cmd_o
);

  sld_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SYNC1;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_SYNC1: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = stat_i.sync_match ? ST_SYNC2 : ST_SYNC1;
        end
      end
      ST_SYNC2: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = stat_i.sync_match ? ST_LEN : ST_SYNC1;
        end
      end
      ST_LEN: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (stat_i.len_ok) begin
            cmd_o.start_pkt = 1'b1;
            state_d         = ST_DATA;
          end else begin
            state_d = ST_SYNC1;
          end
        end
      end
      ST_DATA: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.data_take = 1'b1;
          if (stat_i.last_byte) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_VERDICT;
          end
        end
      end
      ST_VERDICT: begin
        unique case (stat_i.verdict)
          V_DROP: begin
            state_d = ST_SYNC1;
          end
          V_PRIMARY: begin
            cmd_o.rd_issue = 1'b1;
            state_d        = ST_SHIFT;
          end
          V_ERROR, V_SIGNAL: begin
            if (stat_i.out_free) begin
              cmd_o.load_single = 1'b1;
              state_d           = ST_SYNC1;
            end
          end
          default: state_d = ST_SYNC1;
        endcase
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (stat_i.field_done) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.rd_issue = 1'b1;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load_field = 1'b1;
          if (stat_i.last_field) begin
            state_d = ST_SYNC1;
          end else begin
            cmd_o.rd_issue = 1'b1;
            state_d        = ST_SHIFT;
          end
        end
      end
      default: state_d = ST_SYNC1;
    endcase
  end

endmodule

/* rtl/core/sld_dpath.sv */
`timescale 1ns / 1ps

module sld_dpath import sld_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] in_byte_i,
  sld_cfg_if.sink    cfg_i,
  sld_res_if.source  res_o,
  input  sld_cmd_t   cmd_i,
  output sld_stat_t  stat_o
);

  // configuration
  logic [7:0] sync_q, prim_id_q, sig_id_q;

  // receive side
  logic [5:0]  exp_len_q, pos_q;
  logic [15:0] crc_q;
  logic [7:0]  id_q, byte1_q, crc_lo_q;
  logic [15:0] crc_word;

  // verdict and counters
  sld_verdict_e verdict_q, verdict_d;
  logic [COUNT_BITS-1:0] good_q, broken_q, checked_q;

  // readout
  logic [STORE_AW-1:0] rd_addr_q;
  logic [3:0]  field_q;
  logic [1:0]  nb_q;
  logic [31:0] asm_q;
  logic [7:0]  rdata;
  logic signed [31:0] field_val;

  // result register
  logic               out_valid_q;
  logic [1:0]         kind_q;
  logic [3:0]         index_q;
  logic signed [31:0] value_q;
  logic               last_q;
  logic [31:0]        good_out_q, broken_out_q, checked_out_q;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q    <= SYNC_RESET;
      prim_id_q <= PRIMARY_RESET;
      sig_id_q  <= SIGNAL_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_SYNC:    sync_q    <= cfg_i.data;
        CFG_PRIMARY: prim_id_q <= cfg_i.data;
        CFG_SIGNAL:  sig_id_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  sld_store_ram #(
    .Depth (STORE_DEPTH),
    .Width (8)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.data_take),
    .waddr_i (pos_q[STORE_AW-1:0]),
    .wdata_i (in_byte_i),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata)
  );

  assign crc_word = {in_byte_i, crc_lo_q};

  always_comb begin
    if (id_q == prim_id_q) begin
      verdict_d = ({2'b00, exp_len_q} == PRIMARY_LEN && crc_word == crc_q) ?
                  V_PRIMARY : V_ERROR;
    end else if (id_q == sig_id_q) begin
      verdict_d = ({2'b00, exp_len_q} == SIGNAL_LEN) ? V_SIGNAL : V_ERROR;
    end else begin
      verdict_d = V_DROP;
    end
  end

  // control side of the receive path and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= '0;
      pos_q     <= '0;
      crc_q     <= '0;
      verdict_q <= V_DROP;
      good_q    <= '0;
      broken_q  <= '0;
      checked_q <= '0;
      rd_addr_q <= FIELD_BASE;
      field_q   <= '0;
      nb_q      <= '0;
    end else begin
      if (cmd_i.start_pkt) begin
        exp_len_q <= in_byte_i[5:0];
        pos_q     <= '0;
        crc_q     <= '0;
      end
      if (cmd_i.data_take) begin
        pos_q <= pos_q + 6'd1;
        if (pos_q < CRC_SPAN) begin
          crc_q <= crc_byte(crc_q, in_byte_i);
        end
      end
      if (cmd_i.finish) begin
        verdict_q <= verdict_d;
        rd_addr_q <= FIELD_BASE;
        field_q   <= '0;
        nb_q      <= '0;
        if (verdict_d != V_DROP) begin
          checked_q <= sat_inc(checked_q);
        end
        if (verdict_d == V_PRIMARY || verdict_d == V_SIGNAL) begin
          good_q <= sat_inc(good_q);
        end
        if (verdict_d == V_ERROR) begin
          broken_q <= sat_inc(broken_q);
        end
      end
      if (cmd_i.rd_issue) begin
        rd_addr_q <= rd_addr_q + STORE_AW'(1);
      end
      if (cmd_i.shift) begin
        nb_q <= nb_q + 2'd1;
      end
      if (cmd_i.load_field) begin
        field_q <= field_q + 4'd1;
        nb_q    <= '0;
      end
    end
  end

  // packet bytes kept outside the store
  always_ff @(posedge clk_i) begin
    if (cmd_i.data_take) begin
      if (pos_q == '0) begin
        id_q <= in_byte_i;
      end
      if (pos_q == SIG_DATA_POS) begin
        byte1_q <= in_byte_i;
      end
      if (pos_q == CRC_LO_POS) begin
        crc_lo_q <= in_byte_i;
      end
    end
    if (cmd_i.shift) begin
      asm_q <= {rdata, asm_q[31:8]};
    end
  end

  // little-endian field from the assembly register
  always_comb begin
    unique case (field_nb_last(field_q))
      2'd3:    field_val = asm_q;
      2'd1:    field_val = {{16{asm_q[31]}}, asm_q[31:16]};
      default: field_val = {24'd0, asm_q[31:24]};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_field || cmd_i.load_single) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_field || cmd_i.load_single) begin
      good_out_q    <= 32'(good_q);
      broken_out_q  <= 32'(broken_q);
      checked_out_q <= 32'(checked_q);
    end
    if (cmd_i.load_field) begin
      kind_q  <= KIND_FIELD;
      index_q <= field_q;
      value_q <= field_val;
      last_q  <= (field_q == LAST_FIELD);
    end else if (cmd_i.load_single) begin
      index_q <= '0;
      last_q  <= 1'b1;
      if (verdict_q == V_SIGNAL) begin
        kind_q  <= KIND_SIGNAL;
        value_q <= {24'd0, byte1_q};
      end else begin
        kind_q  <= KIND_ERROR;
        value_q <= '0;
      end
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.packet_kind    = kind_q;
  assign res_o.field_index    = index_q;
  assign res_o.field_value    = value_q;
  assign res_o.last_of_packet = last_q;
  assign res_o.good_count     = good_out_q;
  assign res_o.broken_count   = broken_out_q;
  assign res_o.checked_count  = checked_out_q;

  assign stat_o.sync_match = (in_byte_i == sync_q);
  assign stat_o.len_ok     = (in_byte_i == PRIMARY_LEN) || (in_byte_i == SIGNAL_LEN);
  assign stat_o.last_byte  = ((pos_q + 6'd1) == exp_len_q);
  assign stat_o.verdict    = verdict_q;
  assign stat_o.field_done = (nb_q == field_nb_last(field_q));
  assign stat_o.last_field = (field_q == LAST_FIELD);
  assign stat_o.out_free   = !out_valid_q || res_o.ready;

endmodule
